// ===== hw/rtl/qty_pkg.sv =====
// ---------------------------------------------------------------------------
// qty_pkg
// Shared widths, constants, codes and the arctangent table for the
// quaternion-to-yaw pipeline.
// ---------------------------------------------------------------------------
package qty_pkg;

   // quaternion component width, signed q1.15
   localparam int QUAT_W = 16;
   // exact product of two components, units of 2^-30
   localparam int PROD_W = 32;
   // squared norm and both atan2 arguments
   localparam int NORM_W = 34;
   // cordic datapath, room for the quarter turn and the cordic gain
   localparam int CORD_W = 36;
   // angle accumulator, a full turn is 2^32
   localparam int ACC_W  = 32;
   localparam int YAW_W  = 16;
   localparam int TOL_W  = 16;
   localparam int TOL_SHIFT = 14;

   localparam int ATAN_LEN   = 24;
   localparam int ATAN_IDX_W = 5;

   localparam int QTY_CORDIC_STAGES = 16;

   localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(64'sd1073741824);
   localparam logic [TOL_W-1:0]         TOL_RESET = 16'd131;
   localparam logic [ACC_W-1:0]         ACC_QUARTER = 32'h4000_0000;
   localparam logic [ACC_W-1:0]         ACC_MINUS_QUARTER = 32'hC000_0000;

   // result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NOT_NORM = 1'b1;

   // payload carried through the cordic stages
   typedef struct packed {
      logic                     reject;
      logic                     zero;
      logic signed [CORD_W-1:0] cx;
      logic signed [CORD_W-1:0] cy;
      logic [ACC_W-1:0]         acc;
   } stage_data_type;

   // atan(2^-i) in units of 2^-32 turns, truncated
   function automatic logic [ACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933405;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335086;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41721;
         5'd15:   val = 32'd20860;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2607;
         5'd19:   val = 32'd1303;
         5'd20:   val = 32'd651;
         5'd21:   val = 32'd325;
         5'd22:   val = 32'd162;
         5'd23:   val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/qty_front.sv =====
// ---------------------------------------------------------------------------
// qty_front
// Three-stage front end: component products, norm and atan2 arguments,
// then the tolerance check and the left half plane pre-rotation.
// ---------------------------------------------------------------------------
module qty_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [qty_pkg::QUAT_W-1:0]    quat_x,
   input  logic signed [qty_pkg::QUAT_W-1:0]    quat_y,
   input  logic signed [qty_pkg::QUAT_W-1:0]    quat_z,
   input  logic signed [qty_pkg::QUAT_W-1:0]    quat_w,
   input  logic [qty_pkg::TOL_W-1:0]            tolerance,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output qty_pkg::stage_data_type              out_data
);
   import qty_pkg::*;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff, wz_ff, xy_ff;
   logic signed [NORM_W-1:0] n2_ff, num_ff, den_ff;
   logic signed [NORM_W-1:0] n2_in, num_in, den_in;
   stage_data_type           s3_data_ff, s3_data_in;

   logic signed [NORM_W-1:0] dev, lim;
   logic signed [CORD_W-1:0] ax, ay;

   // bubble-collapsing ready chain
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: squares and cross products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_ready && in_valid) begin
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         ww_ff <= quat_w * quat_w;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
      end
   end

   // stage 2: squared norm and both atan2 arguments
   assign n2_in  = NORM_W'(xx_ff) + NORM_W'(yy_ff) + NORM_W'(zz_ff) + NORM_W'(ww_ff);
   assign den_in = NORM_W'(xx_ff) + NORM_W'(ww_ff) - NORM_W'(yy_ff) - NORM_W'(zz_ff);
   assign num_in = (NORM_W'(wz_ff) + NORM_W'(xy_ff)) <<< 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         n2_ff  <= n2_in;
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // stage 3: tolerance window and quarter turn into the right half plane
   assign dev = n2_ff - NORM_ONE;
   assign lim = NORM_W'({tolerance, {TOL_SHIFT{1'b0}}});
   assign ax  = CORD_W'(den_ff);
   assign ay  = CORD_W'(num_ff);

   always_comb begin
      s3_data_in.reject = (dev > lim) || (dev < -lim);
      s3_data_in.zero   = (den_ff == '0) && (num_ff == '0);
      if (ax < 0) begin
         if (ay >= 0) begin
            s3_data_in.cx  = ay;
            s3_data_in.cy  = -ax;
            s3_data_in.acc = ACC_QUARTER;
         end else begin
            s3_data_in.cx  = -ay;
            s3_data_in.cy  = ax;
            s3_data_in.acc = ACC_MINUS_QUARTER;
         end
      end else begin
         s3_data_in.cx  = ax;
         s3_data_in.cy  = ay;
         s3_data_in.acc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

// ===== hw/rtl/qty_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// qty_cordic_stage
// One registered vectoring micro-rotation with a fixed shift.
// ---------------------------------------------------------------------------
module qty_cordic_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qty_pkg::stage_data_type  in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output qty_pkg::stage_data_type  out_data
);
   import qty_pkg::*;

   logic                     valid_ff;
   stage_data_type           data_ff, data_in;
   logic signed [CORD_W-1:0] cx, cy, dx, dy;
   logic [ACC_W-1:0]         step;

   assign in_ready = !valid_ff || out_ready;

   // rotate towards the x axis by atan(2^-i)
   assign cx   = in_data.cx;
   assign cy   = in_data.cy;
   assign dx   = cy >>> STAGE_IDX;
   assign dy   = cx >>> STAGE_IDX;
   assign step = atan_entry(ATAN_IDX_W'(STAGE_IDX));

   always_comb begin
      data_in = in_data;
      if (cy >= 0) begin
         data_in.cx  = cx + dx;
         data_in.cy  = cy - dy;
         data_in.acc = in_data.acc + step;
      end else begin
         data_in.cx  = cx - dx;
         data_in.cy  = cy + dy;
         data_in.acc = in_data.acc - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/quaternion_to_yaw_core.sv =====
// Quaternion to yaw: takes one quaternion (x, y, z, w, signed q1.15) per beat
// and returns its yaw as a signed 16-bit binary angle (32768 is pi) with a
// status bit. Quaternions whose squared norm lies more than norm_tolerance
// (units of 2^-16) away from one are flagged not normalised with a yaw of
// zero. The pipeline takes one quaternion every cycle while the result side
// does not stall it; a result passes through three front-end stages, one
// register per cordic micro-rotation and the output register. Back-pressure
// on the result side stalls the pipeline stage by stage, empty stages keep
// filling. norm_tolerance is written through the csr port, which is always
// ready.
// ---------------------------------------------------------------------------
// quaternion_to_yaw_core
// Top level: tolerance register, front end, cordic chain and output register.
// ---------------------------------------------------------------------------
module quaternion_to_yaw_core #(
   parameter int CORDIC_STAGES = qty_pkg::QTY_CORDIC_STAGES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [qty_pkg::QUAT_W-1:0] req_quat_x,
   input  logic signed [qty_pkg::QUAT_W-1:0] req_quat_y,
   input  logic signed [qty_pkg::QUAT_W-1:0] req_quat_z,
   input  logic signed [qty_pkg::QUAT_W-1:0] req_quat_w,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [qty_pkg::YAW_W-1:0]  rsp_yaw_angle,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qty_pkg::TOL_W-1:0]         csr_norm_tolerance
);
   import qty_pkg::*;

   logic [TOL_W-1:0] tol_ff;

   logic           chain_valid [0:CORDIC_STAGES];
   logic           chain_ready [0:CORDIC_STAGES];
   stage_data_type chain_data  [0:CORDIC_STAGES];

   logic                    rsp_valid_ff;
   logic signed [YAW_W-1:0] rsp_yaw_ff, rsp_yaw_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    last_valid, last_ready;
   stage_data_type          last_data;

   // tolerance register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_norm_tolerance;
      end
   end

   // products, norm check and pre-rotation
   qty_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .quat_w    (req_quat_w),
      .tolerance (tol_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // cordic micro-rotation chain
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      qty_cordic_stage #(
         .STAGE_IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign last_valid = chain_valid[CORDIC_STAGES];
   assign last_data  = chain_data[CORDIC_STAGES];
   assign last_ready = !rsp_valid_ff || rsp_ready;
   assign chain_ready[CORDIC_STAGES] = last_ready;

   // round the angle to 16 bits, force zero on reject or null vector
   always_comb begin
      if (last_data.reject || last_data.zero) begin
         rsp_yaw_in = '0;
      end else begin
         rsp_yaw_in = YAW_W'(last_data.acc[ACC_W-1 -: YAW_W]
                      + {{(YAW_W-1){1'b0}}, last_data.acc[ACC_W-YAW_W-1]});
      end
      rsp_status_in = last_data.reject ? STATUS_NOT_NORM : STATUS_OK;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_ready) begin
         rsp_valid_ff <= last_valid;
      end
      if (last_ready && last_valid) begin
         rsp_yaw_ff    <= rsp_yaw_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yaw_angle = rsp_yaw_ff;
   assign rsp_status    = rsp_status_ff;

   // rejected beats always carry a zero angle
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_NOT_NORM) |-> rsp_yaw_ff == '0)
      else $error("rejected beat with non-zero yaw");

   // a stalled last cordic stage keeps its beat
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      last_valid && !last_ready |=> last_valid && $stable(last_data))
      else $error("last cordic stage lost a stalled beat");

   // a taken result is not shown again without a new beat
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !last_valid |=> !rsp_valid_ff)
      else $error("result beat repeated");

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule
